[sv/mlr_pkg.sv]
package mlr_pkg;

    localparam int COORD_BITS = 12;
    localparam int CUR_W      = COORD_BITS + 2;
    localparam int DEC_W      = COORD_BITS + 4;
    localparam int COLOR_W    = 24;

    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_ADVANCE = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        OCT_SHALLOW     = 2'd0,
        OCT_STEEP       = 2'd1,
        OCT_SHALLOW_MIR = 2'd2,
        OCT_STEEP_MIR   = 2'd3
    } t_octant;

    typedef struct packed {
        t_opcode                       opcode;
        logic signed [COORD_BITS-1:0]  start_x;
        logic signed [COORD_BITS-1:0]  start_y;
        logic signed [COORD_BITS-1:0]  end_x;
        logic signed [COORD_BITS-1:0]  end_y;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_BITS-1:0]  pixel_x;
        logic signed [COORD_BITS-1:0]  pixel_y;
        logic        [COLOR_W-1:0]     color;
        logic                          last;
    } t_out_item;

    typedef struct packed {
        logic                          active;
        logic signed [COORD_BITS-1:0]  cur_x;
        logic signed [CUR_W-1:0]       cur_y;
        logic signed [DEC_W-1:0]       decision;
        logic signed [DEC_W-1:0]       step_east;
        logic signed [DEC_W-1:0]       step_diag;
        logic signed [CUR_W-1:0]       major_end;
        t_octant                       octant;
        logic signed [COORD_BITS-1:0]  mirror_row;
    } t_line_state;

    function automatic logic is_steep(input t_octant m);
        return (m == OCT_STEEP) || (m == OCT_STEEP_MIR);
    endfunction

    function automatic logic is_mirrored(input t_octant m);
        return (m == OCT_SHALLOW_MIR) || (m == OCT_STEEP_MIR);
    endfunction

endpackage

[sv/mlr_setup.sv]
module mlr_setup
    import mlr_pkg::*;
(
    input  t_in_item    i_item,
    output t_line_state o_state
);

    logic                          swap;
    logic signed [COORD_BITS-1:0]  x0;
    logic signed [COORD_BITS-1:0]  y0;
    logic signed [COORD_BITS-1:0]  x1;
    logic signed [COORD_BITS-1:0]  y1;
    logic signed [DEC_W-1:0]       dx;
    logic signed [DEC_W-1:0]       dy;
    logic signed [DEC_W-1:0]       ady;
    t_octant                       mode;

    assign swap = i_item.start_x > i_item.end_x;
    assign x0   = swap ? i_item.end_x   : i_item.start_x;
    assign y0   = swap ? i_item.end_y   : i_item.start_y;
    assign x1   = swap ? i_item.start_x : i_item.end_x;
    assign y1   = swap ? i_item.start_y : i_item.end_y;
    assign dx   = DEC_W'(x1) - DEC_W'(x0);
    assign dy   = DEC_W'(y1) - DEC_W'(y0);

    always_comb begin
        if (dy >= 0) begin
            mode = (dy <= dx) ? OCT_SHALLOW : OCT_STEEP;
        end else begin
            mode = (dy >= -dx) ? OCT_SHALLOW_MIR : OCT_STEEP_MIR;
        end
    end

    assign ady = is_mirrored(mode) ? -dy : dy;

    always_comb begin
        o_state.active     = (dx != '0) || (dy != '0);
        o_state.cur_x      = x0;
        o_state.cur_y      = CUR_W'(y0);
        o_state.octant     = mode;
        o_state.mirror_row = y0;
        if (is_steep(mode)) begin
            o_state.decision  = ady - (dx + dx);
            o_state.step_east = -(dx + dx);
            o_state.step_diag = (ady - dx) + (ady - dx);
            o_state.major_end = CUR_W'(DEC_W'(y0) + ady);
        end else begin
            o_state.decision  = dx - (ady + ady);
            o_state.step_east = -(ady + ady);
            o_state.step_diag = (dx - ady) + (dx - ady);
            o_state.major_end = CUR_W'(x1);
        end
    end

endmodule

[sv/midpoint_line_rasterizer_core.sv]
// Midpoint line generator for all octants. A load transaction (opcode load) takes two endpoints,
// sets up the line and returns its first pixel; each advance transaction returns the next pixel,
// with last set on the final one. A zero-length line and an advance with no line in progress
// return nothing. One transaction is taken every cycle unless the output is stalled: the setup and
// the single step of the decision term both fit between the line state registers and the output
// register, so pixels stream at one per clock unless stalled, each in the cycle after its transaction.
// The output register lets a new transaction in while a pixel is still waiting whenever the
// downstream side takes it in the same cycle. The pixel colour is written through the
// configuration channel, which is always ready, and must only change while no line is running.
module midpoint_line_rasterizer_core
    import mlr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [COLOR_W-1:0] i_cfg_data
);

    t_line_state               r_st;
    t_line_state               n_st;
    t_line_state               setup_st;
    t_line_state               adv_st;
    t_out_item                 r_out;
    t_out_item                 n_out;
    logic                      r_out_valid;
    logic [COLOR_W-1:0]        r_color;
    logic                      in_fire;
    logic                      is_load;
    logic                      emit;
    logic signed [CUR_W-1:0]   pos;
    logic signed [CUR_W-1:0]   out_y;
    logic                      fin;

    mlr_setup u_setup (
        .i_item  (i_in_data),
        .o_state (setup_st)
    );

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;
    assign in_fire     = i_in_valid && o_in_ready;
    assign is_load     = i_in_data.opcode == OP_LOAD;

    // one step along the major axis
    always_comb begin
        adv_st = r_st;
        if (is_steep(r_st.octant)) begin
            adv_st.cur_y = r_st.cur_y + CUR_W'(1);
            if (r_st.decision > 0) begin
                adv_st.decision = r_st.decision + r_st.step_east;
            end else begin
                adv_st.decision = r_st.decision + r_st.step_diag;
                adv_st.cur_x    = r_st.cur_x + COORD_BITS'(1);
            end
        end else begin
            adv_st.cur_x = r_st.cur_x + COORD_BITS'(1);
            if (r_st.decision > 0) begin
                adv_st.decision = r_st.decision + r_st.step_east;
            end else begin
                adv_st.decision = r_st.decision + r_st.step_diag;
                adv_st.cur_y    = r_st.cur_y + CUR_W'(1);
            end
        end
    end

    always_comb begin
        n_st = r_st;
        emit = 1'b0;
        if (in_fire) begin
            if (is_load) begin
                n_st = setup_st;
                emit = setup_st.active;
            end else if (r_st.active) begin
                n_st = adv_st;
                emit = 1'b1;
            end
        end
        pos   = is_steep(n_st.octant) ? n_st.cur_y : CUR_W'(n_st.cur_x);
        fin   = pos == n_st.major_end;
        out_y = is_mirrored(n_st.octant)
              ? CUR_W'(n_st.mirror_row) + CUR_W'(n_st.mirror_row) - n_st.cur_y
              : n_st.cur_y;
        n_out.pixel_x = n_st.cur_x;
        n_out.pixel_y = out_y[COORD_BITS-1:0];
        n_out.color   = r_color;
        n_out.last    = fin;
        if (emit && fin) begin
            n_st.active = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= '0;
            r_out_valid <= 1'b0;
            r_color     <= '0;
        end else begin
            r_st <= n_st;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_color <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && n_out.last) |=> !r_st.active)
        else $error("line still active after last pixel");

    a_idle_advance_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !is_load && !r_st.active) |=> !o_out_valid)
        else $error("pixel from advance with no line");

    a_zero_length_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && is_load && i_in_data.start_x == i_in_data.end_x
            && i_in_data.start_y == i_in_data.end_y) |=> (!o_out_valid && !r_st.active))
        else $error("zero-length line produced output");

    a_load_first_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && is_load && setup_st.active)
            |=> (o_out_valid && !o_out_data.last && r_st.active))
        else $error("first pixel of a line flagged last");

endmodule
